// ===== sv/dcrc_pkg.sv =====
// dcrc_pkg: shared widths, register indexes, control struct and clamp helper
// for the disc/ring coverage pipeline. No dependencies.
package dcrc_pkg;

  // Fixed-point and tile limits
  localparam int FRAC_BITS = 8;
  localparam int MAX_SIDE  = 130;

  // Port field widths
  localparam int COORD_W    = 8;
  localparam int RAD_W      = 15;
  localparam int SIDE_W     = 8;
  localparam int ALPHA_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Derived datapath widths
  localparam int OFS_W       = $clog2(2 * MAX_SIDE);        // |2*dx| in pixels
  localparam int SUM_W       = 2 * OFS_W + 1;               // mx^2 + my^2
  localparam int S_W         = SUM_W + 2 * (FRAC_BITS - 1); // squared distance, Q.2F
  localparam int RT_W        = (S_W + 1) / 2;               // root bits
  localparam int S_EW        = 2 * RT_W;                    // radicand, even width
  localparam int D_W         = RT_W + 1;                    // rounded distance
  localparam int CV_W        = D_W + 2;                     // signed coverage sum
  localparam int COV_W       = FRAC_BITS + 1;               // coverage 0..1.0
  localparam int SQRT_STAGES = 6;
  localparam int SQRT_STEPS  = (RT_W + SQRT_STAGES - 1) / SQRT_STAGES;

  localparam int ONE_Q  = 1 << FRAC_BITS;
  localparam int HALF_Q = 1 << (FRAC_BITS - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIUS     = 2'd0,
    REG_RING_WIDTH = 2'd1,
    REG_TILE_SIDE  = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic valid;
    logic outside;
  } pix_ctl_t;

  function automatic logic [COV_W-1:0] clamp_unit(input logic signed [CV_W-1:0] v);
    logic [COV_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed(CV_W'(ONE_Q))) begin
      r = COV_W'(ONE_Q);
    end else begin
      r = COV_W'(v);
    end
    return r;
  endfunction

endpackage

// ===== sv/disc_ring_coverage_alpha_top.sv =====
// disc_ring_coverage_alpha_top: antialiased disc/ring alpha per tile pixel.
// Instantiates dcrc_offset, dcrc_sqrt and dcrc_shade; depends on dcrc_pkg.
//
// Channel    Direction  Transaction when            Payload
// ---------  ---------  --------------------------  -----------------------------
// pixel      in         start && !busy              pixel_col_i, pixel_row_i
// result     out        alpha_valid_o (one cycle)   alpha_o
// config     in         cfg_valid_i && cfg_ready_o  cfg_index_i, cfg_data_i
//
// One pixel is taken every clock; busy never rises.
// Pipeline: 2 offset/square stages, 6 root stages, 1 rounding stage,
// 2 coverage/alpha stages. The square root sets the depth.
// The result strobe is a single cycle; the receiver cannot stall, so no
// back-pressure path exists and nothing is held.
// Reset clears the valid bits and the registers (radius 0, width 0, side 2).
module disc_ring_coverage_alpha_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // pixel transactions
  input  logic                           start,
  output logic                           busy,
  input  logic [dcrc_pkg::COORD_W-1:0]   pixel_col_i,
  input  logic [dcrc_pkg::COORD_W-1:0]   pixel_row_i,
  // results
  output logic [dcrc_pkg::ALPHA_W-1:0]   alpha_o,
  output logic                           alpha_valid_o,
  // configuration writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [dcrc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [dcrc_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import dcrc_pkg::*;

  logic [RAD_W-1:0]  radius_q, radius_d;
  logic [RAD_W-1:0]  ring_width_q, ring_width_d;
  logic [SIDE_W-1:0] tile_side_q, tile_side_d;

  pix_ctl_t          ctl_sq, ctl_dist;
  logic [S_EW-1:0]   sq;
  logic [D_W-1:0]    pix_dist;
  logic              in_valid;

  // Fully pipelined, never stalls
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign in_valid    = start && !busy;

  // Register file; unknown indexes are dropped
  always_comb begin
    radius_d     = radius_q;
    ring_width_d = ring_width_q;
    tile_side_d  = tile_side_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_RADIUS:     radius_d     = cfg_data_i[RAD_W-1:0];
        REG_RING_WIDTH: ring_width_d = cfg_data_i[RAD_W-1:0];
        REG_TILE_SIDE:  tile_side_d  = cfg_data_i[SIDE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q     <= '0;
      ring_width_q <= '0;
      tile_side_q  <= SIDE_W'(2);
    end else begin
      radius_q     <= radius_d;
      ring_width_q <= ring_width_d;
      tile_side_q  <= tile_side_d;
    end
  end

  // Offsets from tile centre and squared distance
  dcrc_offset u_offset (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .pixel_col_i (pixel_col_i),
    .pixel_row_i (pixel_row_i),
    .tile_side_i (tile_side_q),
    .ctl_o       (ctl_sq),
    .sq_o        (sq)
  );

  // Distance, rounded to nearest 1/256 pixel
  dcrc_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl_sq),
    .sq_i   (sq),
    .ctl_o  (ctl_dist),
    .dist_o (pix_dist)
  );

  // Coverage and alpha
  dcrc_shade u_shade (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl_dist),
    .dist_i        (pix_dist),
    .radius_i      (radius_q),
    .ring_width_i  (ring_width_q),
    .alpha_o       (alpha_o),
    .alpha_valid_o (alpha_valid_o)
  );

endmodule

// ===== sv/dcrc_offset.sv =====
// dcrc_offset: two pipeline stages - tile bounds check and centre offsets,
// then squared offset sum scaled to Q.2F. Depends on dcrc_pkg.
module dcrc_offset (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic [dcrc_pkg::COORD_W-1:0]  pixel_col_i,
  input  logic [dcrc_pkg::COORD_W-1:0]  pixel_row_i,
  input  logic [dcrc_pkg::SIDE_W-1:0]   tile_side_i,
  output dcrc_pkg::pix_ctl_t            ctl_o,
  output logic [dcrc_pkg::S_EW-1:0]     sq_o
);
  import dcrc_pkg::*;

  logic [SIDE_W-1:0]         side_eff;
  logic signed [COORD_W+1:0] twice_x, twice_y;
  logic [COORD_W+1:0]        mag_x, mag_y;
  logic [OFS_W-1:0]          mx_d, mx_q, my_d, my_q;
  pix_ctl_t                  ctl_a_d, ctl_a_q, ctl_b_q;
  logic [SUM_W-1:0]          sum;
  logic [S_EW-1:0]           sq_d, sq_q;

  // Stage A: effective side, bounds, |2*d| per axis
  always_comb begin
    if (int'(tile_side_i) > MAX_SIDE) begin
      side_eff = SIDE_W'(MAX_SIDE);
    end else begin
      side_eff = tile_side_i;
    end
    twice_x = $signed({1'b0, pixel_col_i, 1'b1}) - $signed({2'b00, side_eff});
    twice_y = $signed({1'b0, pixel_row_i, 1'b1}) - $signed({2'b00, side_eff});
    mag_x   = twice_x[COORD_W+1] ? (COORD_W+2)'(0) - twice_x : twice_x;
    mag_y   = twice_y[COORD_W+1] ? (COORD_W+2)'(0) - twice_y : twice_y;
    mx_d    = OFS_W'(mag_x);
    my_d    = OFS_W'(mag_y);
    ctl_a_d.valid   = in_valid_i;
    ctl_a_d.outside = (pixel_col_i >= side_eff) || (pixel_row_i >= side_eff);
  end

  // Stage B: (m<<(F-1))^2 summed = (mx^2 + my^2) << 2(F-1)
  always_comb begin
    sum  = SUM_W'(mx_q) * SUM_W'(mx_q) + SUM_W'(my_q) * SUM_W'(my_q);
    sq_d = S_EW'(sum) << (2 * (FRAC_BITS - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_a_q <= '0;
      ctl_b_q <= '0;
    end else begin
      ctl_a_q <= ctl_a_d;
      ctl_b_q <= ctl_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mx_q <= mx_d;
    my_q <= my_d;
    sq_q <= sq_d;
  end

  assign ctl_o = ctl_b_q;
  assign sq_o  = sq_q;

endmodule

// ===== sv/dcrc_sqrt.sv =====
// dcrc_sqrt: pipelined digit-by-digit square root, a few root bits per stage,
// then a round-to-nearest stage. Depends on dcrc_pkg.
module dcrc_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  dcrc_pkg::pix_ctl_t         ctl_i,
  input  logic [dcrc_pkg::S_EW-1:0]  sq_i,
  output dcrc_pkg::pix_ctl_t         ctl_o,
  output logic [dcrc_pkg::D_W-1:0]   dist_o
);
  import dcrc_pkg::*;

  logic [S_EW-1:0] rem_in  [SQRT_STAGES];
  logic [S_EW-1:0] res_in  [SQRT_STAGES];
  pix_ctl_t        ctl_in  [SQRT_STAGES];
  logic [S_EW-1:0] rem_d   [SQRT_STAGES];
  logic [S_EW-1:0] res_d   [SQRT_STAGES];
  logic [S_EW-1:0] rem_q   [SQRT_STAGES];
  logic [S_EW-1:0] res_q   [SQRT_STAGES];
  pix_ctl_t        ctl_q   [SQRT_STAGES];

  logic [D_W-1:0]  dist_d, dist_q;
  pix_ctl_t        ctl_out_q;

  for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_stage
    if (g == 0) begin : g_first
      assign rem_in[g] = sq_i;
      assign res_in[g] = '0;
      assign ctl_in[g] = ctl_i;
    end else begin : g_next
      assign rem_in[g] = rem_q[g-1];
      assign res_in[g] = res_q[g-1];
      assign ctl_in[g] = ctl_q[g-1];
    end

    always_comb begin
      logic [S_EW-1:0] rem;
      logic [S_EW-1:0] res;
      logic [S_EW-1:0] bitv;
      logic [S_EW:0]   trial;
      rem   = rem_in[g];
      res   = res_in[g];
      bitv  = '0;
      trial = '0;
      for (int k = 0; k < SQRT_STEPS; k++) begin
        if (g * SQRT_STEPS + k < RT_W) begin
          bitv  = S_EW'(1) << (S_EW - 2 - 2 * (g * SQRT_STEPS + k));
          trial = {1'b0, res} + {1'b0, bitv};
          if ({1'b0, rem} >= trial) begin
            rem = rem - S_EW'(trial);
            res = (res >> 1) + bitv;
          end else begin
            res = res >> 1;
          end
        end
      end
      rem_d[g] = rem;
      res_d[g] = res;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[g] <= '0;
      end else begin
        ctl_q[g] <= ctl_in[g];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[g] <= rem_d[g];
      res_q[g] <= res_d[g];
    end
  end

  // Round to nearest: floor root, plus one when the remainder exceeds it
  assign dist_d = D_W'(res_q[SQRT_STAGES-1])
                + D_W'(rem_q[SQRT_STAGES-1] > res_q[SQRT_STAGES-1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_out_q <= '0;
    end else begin
      ctl_out_q <= ctl_q[SQRT_STAGES-1];
    end
  end

  always_ff @(posedge clk_i) begin
    dist_q <= dist_d;
  end

  assign ctl_o  = ctl_out_q;
  assign dist_o = dist_q;

endmodule

// ===== sv/dcrc_shade.sv =====
// dcrc_shade: coverage from radius, ring width and distance, then scaling
// to an 8-bit alpha with rounding. Two register stages. Depends on dcrc_pkg.
module dcrc_shade (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dcrc_pkg::pix_ctl_t          ctl_i,
  input  logic [dcrc_pkg::D_W-1:0]    dist_i,
  input  logic [dcrc_pkg::RAD_W-1:0]  radius_i,
  input  logic [dcrc_pkg::RAD_W-1:0]  ring_width_i,
  output logic [dcrc_pkg::ALPHA_W-1:0] alpha_o,
  output logic                        alpha_valid_o
);
  import dcrc_pkg::*;

  logic signed [CV_W-1:0]  outer_raw, inner_raw;
  logic [COV_W-1:0]        outer_c, inner_c;
  logic signed [COV_W:0]   diff;
  logic [COV_W-1:0]        cov_d, cov_q;
  logic                    valid_q, alpha_valid_q;
  logic [COV_W+7:0]        scaled;
  logic [ALPHA_W-1:0]      alpha_d, alpha_q;

  // Stage 1: clamped outer coverage, less clamped inner coverage for a ring
  always_comb begin
    outer_raw = $signed(CV_W'(radius_i)) - $signed(CV_W'(dist_i))
              + $signed(CV_W'(HALF_Q));
    inner_raw = outer_raw - $signed(CV_W'(ring_width_i));
    outer_c   = clamp_unit(outer_raw);
    inner_c   = clamp_unit(inner_raw);
    diff      = $signed({1'b0, outer_c}) - $signed({1'b0, inner_c});
    if (ctl_i.outside) begin
      cov_d = '0;
    end else if (ring_width_i == '0) begin
      cov_d = outer_c;
    end else if (diff[COV_W]) begin
      cov_d = '0;
    end else begin
      cov_d = diff[COV_W-1:0];
    end
  end

  // Stage 2: cov * 255 + half, as (cov << 8) - cov
  always_comb begin
    scaled  = {cov_q, 8'h00} - (COV_W + 8)'(cov_q) + (COV_W + 8)'(HALF_Q);
    alpha_d = scaled[FRAC_BITS +: ALPHA_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q       <= 1'b0;
      alpha_valid_q <= 1'b0;
    end else begin
      valid_q       <= ctl_i.valid;
      alpha_valid_q <= valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cov_q   <= cov_d;
    alpha_q <= alpha_d;
  end

  assign alpha_o       = alpha_q;
  assign alpha_valid_o = alpha_valid_q;

endmodule

// ===== sim/disc_ring_coverage_alpha_top_tb.sv =====
`timescale 1ns / 100ps
// disc_ring_coverage_alpha_top_tb: self-checking bench for the disc/ring coverage alpha block.
// Needs dcrc_pkg and the RTL of disc_ring_coverage_alpha_top; an internal predictor
// computes the expected alpha for every pixel transaction.
module disc_ring_coverage_alpha_top_tb;
  import dcrc_pkg::*;

  localparam int CLK_PERIOD = 10;
  localparam int RST_CYCLES = 7;
  localparam int MAX_GAP    = 18;
  localparam int N_PHASES   = 42;
  localparam int PIX_PER_PH = 25;
  localparam int TAIL_CYCLES = 16;
  // the timeout allows many times the worst-case run length
  localparam longint TIMEOUT_NS = 2_000_000;

  // index past the register list; writes to it must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT
  // ---------------------------------------------------------------------------
  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  logic [COORD_W-1:0]    pixel_col_i;
  logic [COORD_W-1:0]    pixel_row_i;
  logic [ALPHA_W-1:0]    alpha_o;
  logic                  alpha_valid_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  disc_ring_coverage_alpha_top u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .pixel_col_i  (pixel_col_i),
    .pixel_row_i  (pixel_row_i),
    .alpha_o      (alpha_o),
    .alpha_valid_o(alpha_valid_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // Predictor: own copy of the registers, updated on each accepted write
  // ---------------------------------------------------------------------------
  logic [RAD_W-1:0]  mdl_radius;
  logic [RAD_W-1:0]  mdl_width;
  logic [SIDE_W-1:0] mdl_side;

  logic [ALPHA_W-1:0] alpha_due[$];   // expected alphas, oldest first

  int n_err;
  int n_pix;
  int n_res;
  int n_partial;
  int n_writes;

  function automatic longint unit_clamp(input longint v);
    if (v < 0) return 0;
    if (v > ONE_Q) return ONE_Q;
    return v;
  endfunction

  // |pixel centre - tile centre| in Q.FRAC_BITS; exact since 2*dx = 2p+1-side
  function automatic longint half_offset_q(input logic [COORD_W-1:0] p, input longint side);
    longint m;
    m = 2 * longint'(p) + 1 - side;
    if (m < 0) m = -m;
    return m << (FRAC_BITS - 1);
  endfunction

  function automatic logic [ALPHA_W-1:0] coverage_alpha(input logic [COORD_W-1:0] col,
                                                        input logic [COORD_W-1:0] row);
    longint side, dx, dy, s, d, t, cov, inner;
    side = (mdl_side > MAX_SIDE) ? MAX_SIDE : longint'(mdl_side);
    if (col >= side || row >= side) return '0;
    dx = half_offset_q(col, side);
    dy = half_offset_q(row, side);
    s  = dx * dx + dy * dy;
    // floor root bit by bit, then round to nearest
    d = 0;
    for (int b = 17; b >= 0; b--) begin
      t = d | (longint'(1) << b);
      if (t * t <= s) d = t;
    end
    if (s - d * d > d) d = d + 1;
    cov = unit_clamp(longint'(mdl_radius) - d + HALF_Q);
    if (mdl_width != 0) begin
      inner = unit_clamp(longint'(mdl_radius) - longint'(mdl_width) - d + HALF_Q);
      cov   = unit_clamp(cov - inner);
    end
    return ALPHA_W'((cov * 255 + HALF_Q) >>> FRAC_BITS);
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    n_err++;
  endtask

  // ---------------------------------------------------------------------------
  // Drivers: change on the falling edge, look at handshakes on the rising edge
  // ---------------------------------------------------------------------------
  // One pixel transaction. start stays high across back-to-back pixels so it
  // never gets two assignments in one step. The expectation is queued at the
  // accepting edge: typed-in where given, otherwise from the predictor.
  task automatic drive_pixel(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row,
                             input int gap, input logic typed, input logic [ALPHA_W-1:0] alpha);
    repeat (gap) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
    @(negedge clk_i);
    start       <= 1'b1;
    pixel_col_i <= col;
    pixel_row_i <= row;
    do @(posedge clk_i); while (busy);
    alpha_due.push_back(typed ? alpha : coverage_alpha(col, row));
    n_pix++;
  endtask

  // Register write; only issued with the pipeline empty, so the predictor
  // copy can be updated straight away.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data,
                           input int gap);
    repeat (gap) @(negedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_RADIUS:     mdl_radius = data[RAD_W-1:0];
      REG_RING_WIDTH: mdl_width  = data[RAD_W-1:0];
      REG_TILE_SIDE:  mdl_side   = data[SIDE_W-1:0];
      default: ;      // spare index: ignored
    endcase
    n_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Drop start and wait for every outstanding alpha; each pixel yields one,
  // so an empty queue means an empty pipeline.
  task automatic settle();
    @(negedge clk_i);
    start <= 1'b0;
    while (alpha_due.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: strobe is one cycle, sampled at the edge that ends it
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    logic [ALPHA_W-1:0] want;
    if (rst_ni && alpha_valid_o) begin
      n_res++;
      if (alpha_o > 0 && alpha_o < 255) n_partial++;
      if (alpha_due.size() == 0) begin
        report_mismatch($sformatf("alpha %0d with no pixel outstanding", alpha_o));
      end else begin
        want = alpha_due.pop_front();
        if (alpha_o !== want)
          report_mismatch($sformatf("alpha got %0d want %0d", alpha_o, want));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Directed rows: register extremes, tile saturation, outside pixels,
  // ring wider than radius, tiny tiles, spare index and masked data bits
  // ---------------------------------------------------------------------------
  typedef enum logic {ROW_WRITE, ROW_PIXEL} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic [COORD_W-1:0]    col;
    logic [COORD_W-1:0]    row;
    logic                  typed;
    logic [ALPHA_W-1:0]    alpha;
  } dir_row_t;

  localparam int N_OPENING = 32;

  dir_row_t opening_rows [N_OPENING] = '{
    // reset values: radius 0, side 2 -> nothing covered
    '{ROW_PIXEL, REG_RADIUS,     16'h0000,   0,   0, 1'b1,   0},
    '{ROW_PIXEL, REG_RADIUS,     16'h0000, 255, 255, 1'b1,   0},
    '{ROW_PIXEL, REG_RADIUS,     16'h0000,   2,   0, 1'b1,   0},
    '{ROW_PIXEL, REG_RADIUS,     16'h0000,   1,   1, 1'b0,   0},
    // full 64-pixel disc on the largest tile
    '{ROW_WRITE, REG_RADIUS,     16'd16384,  0,   0, 1'b0,   0},
    '{ROW_WRITE, REG_TILE_SIDE,  16'd130,    0,   0, 1'b0,   0},
    '{ROW_PIXEL, REG_RADIUS,     16'h0000,  64,  64, 1'b1, 255},
    '{ROW_PIXEL, REG_RADIUS,     16'h0000,   0,   0, 1'b1,   0},
    '{ROW_PIXEL, REG_RADIUS,     16'h0000, 129,  64, 1'b0,   0},
    '{ROW_PIXEL, REG_RADIUS,     16'h0000, 130,   0, 1'b1,   0},
    // oversize tile saturates to the maximum side
    '{ROW_WRITE, REG_TILE_SIDE,  16'd255,    0,   0, 1'b0,   0},
    '{ROW_PIXEL, REG_RADIUS,     16'h0000, 129, 129, 1'b0,   0},
    '{ROW_PIXEL, REG_RADIUS,     16'h0000, 200,   5, 1'b1,   0},
    // ring wider than the radius behaves as a disc
    '{ROW_WRITE, REG_RING_WIDTH, 16'h7FFF,   0,   0, 1'b0,   0},
    '{ROW_PIXEL, REG_RADIUS,     16'h0000,  64,  64, 1'b1, 255},
    // one-pixel ring: centre is hollow
    '{ROW_WRITE, REG_RING_WIDTH, 16'd256,    0,   0, 1'b0,   0},
    '{ROW_PIXEL, REG_RADIUS,     16'h0000,  64,  64, 1'b1,   0},
    '{ROW_PIXEL, REG_RADIUS,     16'h0000,   0,  64, 1'b0,   0},
    // tiles below two pixels
    '{ROW_WRITE, REG_TILE_SIDE,  16'd1,      0,   0, 1'b0,   0},
    '{ROW_PIXEL, REG_RADIUS,     16'h0000,   0,   0, 1'b0,   0},
    '{ROW_WRITE, REG_TILE_SIDE,  16'd0,      0,   0, 1'b0,   0},
    '{ROW_PIXEL, REG_RADIUS,     16'h0000,   0,   0, 1'b1,   0},
    // spare index must leave the zero side in place
    '{ROW_WRITE, REG_SPARE,      16'hFFFF,   0,   0, 1'b0,   0},
    '{ROW_PIXEL, REG_RADIUS,     16'h0000,   0,   0, 1'b1,   0},
    // unused data bits set: radius 192, side 6, width 0
    '{ROW_WRITE, REG_RADIUS,     16'h80C0,   0,   0, 1'b0,   0},
    '{ROW_WRITE, REG_TILE_SIDE,  16'h3F06,   0,   0, 1'b0,   0},
    '{ROW_WRITE, REG_RING_WIDTH, 16'h8000,   0,   0, 1'b0,   0},
    '{ROW_PIXEL, REG_RADIUS,     16'h0000,   2,   2, 1'b0,   0},
    '{ROW_PIXEL, REG_RADIUS,     16'h0000,   0,   0, 1'b0,   0},
    '{ROW_PIXEL, REG_RADIUS,     16'h0000,   5,   3, 1'b0,   0},
    '{ROW_PIXEL, REG_RADIUS,     16'h0000,   4,   1, 1'b0,   0},
    '{ROW_PIXEL, REG_RADIUS,     16'h0000,   6,   2, 1'b1,   0}
  };

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [RAD_W-1:0]   rad;
    logic [RAD_W-1:0]   wid;
    logic [SIDE_W-1:0]  sd;
    longint             sd_eff;
    logic [COORD_W-1:0] c;
    logic [COORD_W-1:0] r;
    bit                 burst;

    rst_ni      = 1'b0;
    start       = 1'b0;
    pixel_col_i = '0;
    pixel_row_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_RADIUS;
    cfg_data_i  = '0;
    mdl_radius  = '0;
    mdl_width   = '0;
    mdl_side    = SIDE_W'(2);
    n_err = 0; n_pix = 0; n_res = 0; n_partial = 0; n_writes = 0;

    repeat (RST_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (opening_rows[i]) begin
      if (opening_rows[i].kind == ROW_WRITE) begin
        settle();
        cfg_write(opening_rows[i].idx, opening_rows[i].data, $urandom_range(0, 3));
      end else begin
        drive_pixel(opening_rows[i].col, opening_rows[i].row, $urandom_range(0, MAX_GAP),
                    opening_rows[i].typed, opening_rows[i].alpha);
      end
    end

    // Random phases: new register set, then a run of pixels. Tiles are mostly
    // sized to the disc so most pixels sit near an edge and give partial alpha.
    for (int ph = 0; ph < N_PHASES; ph++) begin
      settle();

      case ($urandom_range(0, 9))
        0:       rad = '0;
        1:       rad = RAD_W'(16384);
        2:       rad = '1;
        3, 4:    rad = RAD_W'($urandom_range(0, 16384));
        default: rad = RAD_W'($urandom_range(0, 4096));
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2, 3: wid = '0;
        4:          wid = ($urandom_range(0, 1) != 0) ? '1 : RAD_W'(rad + 1);
        default:    wid = RAD_W'($urandom_range(1, (rad == 0) ? 1 : rad));
      endcase
      case ($urandom_range(0, 9))
        0: sd = SIDE_W'($urandom_range(0, 255));
        1: begin
          case ($urandom_range(0, 5))
            0:       sd = SIDE_W'(0);
            1:       sd = SIDE_W'(1);
            2:       sd = SIDE_W'(2);
            3:       sd = SIDE_W'(MAX_SIDE);
            4:       sd = SIDE_W'(MAX_SIDE + 1);
            default: sd = '1;
          endcase
        end
        default: begin
          // ceil(2*radius)+2, capped at the port width
          sd_eff = ((2 * longint'(rad) + 255) >> FRAC_BITS) + 2;
          sd = (sd_eff > 255) ? '1 : SIDE_W'(sd_eff);
        end
      endcase

      // spare bits of the data bus toggle too
      cfg_write(REG_RADIUS, {1'($urandom_range(0, 1)), rad}, $urandom_range(0, MAX_GAP));
      cfg_write(REG_RING_WIDTH, {1'($urandom_range(0, 1)), wid}, $urandom_range(0, MAX_GAP));
      cfg_write(REG_TILE_SIDE, {8'($urandom_range(0, 255)), sd}, $urandom_range(0, MAX_GAP));
      if ($urandom_range(0, 5) == 0)
        cfg_write(REG_SPARE, CFG_DATA_W'($urandom), $urandom_range(0, MAX_GAP));

      sd_eff = (sd > MAX_SIDE) ? MAX_SIDE : longint'(sd);
      burst  = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < PIX_PER_PH; k++) begin
        if (sd_eff != 0 && $urandom_range(0, 99) < 85) c = COORD_W'($urandom_range(0, sd_eff - 1));
        else                                            c = COORD_W'($urandom_range(0, 255));
        if (sd_eff != 0 && $urandom_range(0, 99) < 85) r = COORD_W'($urandom_range(0, sd_eff - 1));
        else                                            r = COORD_W'($urandom_range(0, 255));
        drive_pixel(c, r, burst ? 0 : $urandom_range(0, MAX_GAP), 1'b0, '0);
      end
    end

    // Drain, then give stray strobes a chance to show
    @(negedge clk_i);
    start <= 1'b0;
    while (alpha_due.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (alpha_due.size() != 0)
      report_mismatch($sformatf("%0d alphas never arrived", alpha_due.size()));

    $display("Coverage run: %0d pixels sent, %0d alphas checked (%0d partial), %0d reg writes",
             n_pix, n_res, n_partial, n_writes);
    $display("Discs, rings, oversize and tiny tiles, outside pixels; %0d mismatches", n_err);
    if (n_err == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("Timed out waiting on a transaction");
    $display("FAIL");
    $finish;
  end

endmodule
